[design/ryp_pkg.sv]
// Shared types, constants and colour arithmetic for the RGB to planar YUV 4:2:0 converter.
package ryp_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_HEIGHT  = 2048;
   localparam int DIM_BITS    = 12;  // configured sizes, up to 4095
   localparam int POS_BITS    = 11;  // column and row positions
   localparam int ADDR_BITS   = 23;
   localparam int CADDR_BITS  = 21;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [DIM_BITS-1:0] MAX_WIDTH_EVEN =
      DIM_BITS'(MAX_WIDTH - (MAX_WIDTH % 2));
   localparam logic [DIM_BITS-1:0] MAX_HEIGHT_DIM = DIM_BITS'(MAX_HEIGHT);

   // register indexes
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_SWAP   = 2'd2;
   localparam logic [1:0] CSR_FLIP   = 2'd3;

   // plane codes
   localparam logic [1:0] PLANE_Y = 2'd0;
   localparam logic [1:0] PLANE_U = 2'd1;
   localparam logic [1:0] PLANE_V = 2'd2;

   // BT.601 integer coefficients
   localparam logic signed [8:0] KY_R = 9'sd66;
   localparam logic signed [8:0] KY_G = 9'sd129;
   localparam logic signed [8:0] KY_B = 9'sd25;
   localparam logic signed [8:0] KU_R = -9'sd38;
   localparam logic signed [8:0] KU_G = -9'sd74;
   localparam logic signed [8:0] KU_B = 9'sd112;
   localparam logic signed [8:0] KV_R = 9'sd112;
   localparam logic signed [8:0] KV_G = -9'sd94;
   localparam logic signed [8:0] KV_B = -9'sd18;
   localparam logic [7:0] BIAS_Y = 8'd16;
   localparam logic [7:0] BIAS_C = 8'd128;

   typedef struct packed {
      logic [DIM_BITS-1:0]  width;       // even, clamped
      logic [DIM_BITS-1:0]  height;      // clamped
      logic                 swap_order;
      logic                 flip_rows;
      logic [ADDR_BITS-1:0] u_base;      // luma plane size
      logic [ADDR_BITS-1:0] v_base;      // luma plus U plane size
   } cfg_type;

   typedef struct packed {
      logic [POS_BITS-1:0] orow;
      logic [POS_BITS-1:0] col;
      logic                chroma;
      logic [7:0]          y;
      logic [7:0]          u;
      logic [7:0]          v;
   } entry_type;

   // floor((k . rgb + 128) / 256) + bias, modulo 256
   function automatic logic [7:0] ryp_scale(
      input logic [7:0]        r,
      input logic [7:0]        g,
      input logic [7:0]        b,
      input logic signed [8:0] kr,
      input logic signed [8:0] kg,
      input logic signed [8:0] kb,
      input logic [7:0]        bias
   );
      logic signed [17:0] sum, rs, gs, bs;
      rs  = $signed({10'b0, r});
      gs  = $signed({10'b0, g});
      bs  = $signed({10'b0, b});
      sum = 18'(kr) * rs + 18'(kg) * gs + 18'(kb) * bs + 18'sd128;
      return sum[15:8] + bias;
   endfunction

endpackage

[design/ryp_front.sv]
// Front end: raster position tracking, row mirroring, chroma selection and colour conversion.
module ryp_front import ryp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic [7:0] req_byte0,
   input  logic [7:0] req_byte1,
   input  logic [7:0] req_byte2,
   input  logic      push_ready,
   output logic      push_valid,
   output entry_type push_entry
);

   logic [POS_BITS-1:0] col_ff, col_in;
   logic [POS_BITS-1:0] row_ff, row_in;
   logic [DIM_BITS-1:0] col_a, row_a, col_n, row_n, orow;
   logic [7:0]          red, green, blue;
   logic                accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      // settle a position left stale by a size change
      col_a = {1'b0, col_ff};
      row_a = {1'b0, row_ff};
      if (col_a >= cfg.width) begin
         col_a = '0;
         row_a = row_a + DIM_BITS'(1);
      end
      if (row_a >= cfg.height) begin
         row_a = '0;
      end
      orow = cfg.flip_rows ? (cfg.height - DIM_BITS'(1) - row_a) : row_a;

      col_n = col_a + DIM_BITS'(1);
      row_n = row_a;
      if (col_n >= cfg.width) begin
         col_n = '0;
         row_n = row_a + DIM_BITS'(1);
         if (row_n >= cfg.height) begin
            row_n = '0;
         end
      end
      col_in = accept ? col_n[POS_BITS-1:0] : col_ff;
      row_in = accept ? row_n[POS_BITS-1:0] : row_ff;
   end

   always_comb begin
      red   = cfg.swap_order ? req_byte2 : req_byte0;
      green = req_byte1;
      blue  = cfg.swap_order ? req_byte0 : req_byte2;
      push_entry.orow   = orow[POS_BITS-1:0];
      push_entry.col    = col_a[POS_BITS-1:0];
      push_entry.chroma = col_a[0] && (orow[0] || (orow == cfg.height - DIM_BITS'(1)));
      push_entry.y = ryp_scale(red, green, blue, KY_R, KY_G, KY_B, BIAS_Y);
      push_entry.u = ryp_scale(red, green, blue, KU_R, KU_G, KU_B, BIAS_C);
      push_entry.v = ryp_scale(red, green, blue, KV_R, KV_G, KV_B, BIAS_C);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

[design/ryp_queue.sv]
// Short queue of converted pixels between front and back end.
module ryp_queue import ryp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      count_in = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[design/ryp_back.sv]
// Back end: buffer addressing and serial issue of luma and chroma writes.
module ryp_back import ryp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  entry_type            pop_entry,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_plane,
   output logic [ADDR_BITS-1:0] rsp_address,
   output logic [7:0]           rsp_sample,
   output logic                 rsp_last
);

   localparam logic [1:0] PH_LUMA = 2'd0;
   localparam logic [1:0] PH_U    = 2'd1;
   localparam logic [1:0] PH_V    = 2'd2;

   // address stage
   logic                  x_valid_ff, x_valid_in;
   logic [ADDR_BITS-1:0]  x_luma_ff, x_luma_in;
   logic [CADDR_BITS-1:0] x_caddr_ff, x_caddr_in;
   logic                  x_chroma_ff;
   logic [7:0]            x_y_ff, x_u_ff, x_v_ff;

   // issue stage
   logic [1:0]           phase_ff, phase_in;
   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           plane_ff, plane_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [7:0]           sample_ff, sample_in;
   logic                 last_ff, last_in;
   logic                 issue, x_done;

   assign issue     = x_valid_ff && (!out_valid_ff || rsp_ready);
   assign x_done    = issue && ((phase_ff == PH_V) || ((phase_ff == PH_LUMA) && !x_chroma_ff));
   assign pop_ready = !x_valid_ff || x_done;

   always_comb begin
      x_luma_in  = ADDR_BITS'(pop_entry.orow) * ADDR_BITS'(cfg.width)
                 + ADDR_BITS'(pop_entry.col);
      x_caddr_in = CADDR_BITS'(pop_entry.orow[POS_BITS-1:1])
                 * CADDR_BITS'(cfg.width[DIM_BITS-1:1])
                 + CADDR_BITS'(pop_entry.col[POS_BITS-1:1]);
      x_valid_in = pop_ready ? pop_valid : x_valid_ff;
   end

   always_comb begin
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      plane_in     = plane_ff;
      addr_in      = addr_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      if (issue) begin
         out_valid_in = 1'b1;
         unique case (phase_ff)
            PH_LUMA: begin
               plane_in  = PLANE_Y;
               addr_in   = x_luma_ff;
               sample_in = x_y_ff;
               last_in   = !x_chroma_ff;
               phase_in  = x_chroma_ff ? PH_U : PH_LUMA;
            end
            PH_U: begin
               plane_in  = PLANE_U;
               addr_in   = cfg.u_base + ADDR_BITS'(x_caddr_ff);
               sample_in = x_u_ff;
               last_in   = 1'b0;
               phase_in  = PH_V;
            end
            PH_V: begin
               plane_in  = PLANE_V;
               addr_in   = cfg.v_base + ADDR_BITS'(x_caddr_ff);
               sample_in = x_v_ff;
               last_in   = 1'b1;
               phase_in  = PH_LUMA;
            end
            default: begin
               phase_in = PH_LUMA;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff   <= 1'b0;
         phase_ff     <= PH_LUMA;
         out_valid_ff <= 1'b0;
      end else begin
         x_valid_ff   <= x_valid_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         x_luma_ff   <= x_luma_in;
         x_caddr_ff  <= x_caddr_in;
         x_chroma_ff <= pop_entry.chroma;
         x_y_ff      <= pop_entry.y;
         x_u_ff      <= pop_entry.u;
         x_v_ff      <= pop_entry.v;
      end
      plane_ff  <= plane_in;
      addr_ff   <= addr_in;
      sample_ff <= sample_in;
      last_ff   <= last_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_plane   = plane_ff;
   assign rsp_address = addr_ff;
   assign rsp_sample  = sample_ff;
   assign rsp_last    = last_ff;

endmodule

[design/rgb_to_yuv420p_planar.sv]
// Top level of the RGB to planar YUV 4:2:0 converter: register file and plane sizes.
//
//   port group  direction  handshake              contents
//   req_        in         req_valid/req_ready    one RGB pixel, source raster order
//   rsp_        out        rsp_valid/rsp_ready    one buffer write: plane, address, sample
//   csr_        in         csr_write              register index and write data
//
// Each pixel yields one write (luma only) or three (luma, U, V); the issue stage sends
// one write per cycle while rsp_ready holds. The first write of a pixel passes the queue,
// the address stage and the output register after the request is taken. A four-entry queue
// lets the front keep taking requests while writes stall. Reset is synchronous; after a
// register write the plane bases settle through the luma size and V base registers.
module rgb_to_yuv420p_planar import ryp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_byte0,
   input  logic [7:0]           req_byte1,
   input  logic [7:0]           req_byte2,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_plane,
   output logic [ADDR_BITS-1:0] rsp_address,
   output logic [7:0]           rsp_sample,
   output logic                 rsp_last,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [DIM_BITS-1:0]  csr_wdata
);

   logic [DIM_BITS-1:0]  width_ff, width_in;
   logic [DIM_BITS-1:0]  height_ff, height_in;
   logic                 swap_ff, swap_in;
   logic                 flip_ff, flip_in;
   logic [ADDR_BITS-1:0] luma_size_ff, luma_size_in;
   logic [ADDR_BITS-1:0] v_base_ff, v_base_in;
   logic [DIM_BITS-1:0]  eff_width, eff_height;
   cfg_type              cfg;

   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_entry, pop_entry;

   // register file: plain writes, no read-back
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      swap_in   = swap_ff;
      flip_in   = flip_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            CSR_SWAP:   swap_in   = csr_wdata[0];
            CSR_FLIP:   flip_in   = csr_wdata[0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(640);
         height_ff <= DIM_BITS'(480);
         swap_ff   <= 1'b0;
         flip_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         swap_ff   <= swap_in;
         flip_ff   <= flip_in;
      end
   end

   // drop the odd bit of the width, then clamp both sizes to the supported range
   always_comb begin
      eff_width = {width_ff[DIM_BITS-1:1], 1'b0};
      if (eff_width < DIM_BITS'(2)) begin
         eff_width = DIM_BITS'(2);
      end else if (eff_width > MAX_WIDTH_EVEN) begin
         eff_width = MAX_WIDTH_EVEN;
      end
      eff_height = height_ff;
      if (eff_height == '0) begin
         eff_height = DIM_BITS'(1);
      end else if (eff_height > MAX_HEIGHT_DIM) begin
         eff_height = MAX_HEIGHT_DIM;
      end
   end

   // plane bases: U follows the luma plane, V follows a quarter-size U plane
   assign luma_size_in = ADDR_BITS'(eff_width) * ADDR_BITS'(eff_height);
   assign v_base_in    = luma_size_ff + (luma_size_ff >> 2);

   always_ff @(posedge clock) begin
      luma_size_ff <= luma_size_in;
      v_base_ff    <= v_base_in;
   end

   always_comb begin
      cfg.width      = eff_width;
      cfg.height     = eff_height;
      cfg.swap_order = swap_ff;
      cfg.flip_rows  = flip_ff;
      cfg.u_base     = luma_size_ff;
      cfg.v_base     = v_base_ff;
   end

   // front: position, mirroring, chroma pick and conversion of each request
   ryp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_byte0  (req_byte0),
      .req_byte1  (req_byte1),
      .req_byte2  (req_byte2),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // hold converted pixels so either side may stall
   ryp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // back: addresses, then advance one write per cycle while the write side is ready
   ryp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_plane   (rsp_plane),
      .rsp_address (rsp_address),
      .rsp_sample  (rsp_sample),
      .rsp_last    (rsp_last)
   );

endmodule

[bench/ryp_write_checker.sv]
// Scoreboard for the converter: predicts the buffer writes of each pixel and checks them.
`timescale 1ns / 1ps

module ryp_write_checker import ryp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [7:0]           req_byte0,
   input  logic [7:0]           req_byte1,
   input  logic [7:0]           req_byte2,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [1:0]           rsp_plane,
   input  logic [ADDR_BITS-1:0] rsp_address,
   input  logic [7:0]           rsp_sample,
   input  logic                 rsp_last,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [DIM_BITS-1:0]  csr_wdata,
   output int                   mismatch_count,
   output int                   writes_awaited
);

   localparam logic [DIM_BITS-1:0] RESET_WIDTH  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] RESET_HEIGHT = DIM_BITS'(480);

   typedef struct packed {
      logic [1:0]           plane;
      logic [ADDR_BITS-1:0] address;
      logic [7:0]           sample;
      logic                 last;
   } buffer_write_type;

   buffer_write_type    awaited_writes[$];
   logic [DIM_BITS-1:0] width_reg;
   logic [DIM_BITS-1:0] height_reg;
   logic                swap_reg;
   logic                flip_reg;
   int unsigned         column_pos;
   int unsigned         row_pos;
   int                  errors;

   // floor((k . rgb + 128) / 256) + bias, wrapped to a byte
   function automatic logic [7:0] bt601_component(input int r, input int g, input int b,
                                                  input int kr, input int kg, input int kb,
                                                  input int bias);
      int acc;
      acc = kr * r + kg * g + kb * b + 128;
      return 8'((acc >>> 8) + bias);
   endfunction

   function automatic void predict_pixel_writes(input logic [7:0] first, input logic [7:0] green,
                                                input logic [7:0] third);
      int unsigned w, h, col, orow, luma_size, chroma_offset;
      int          r, g, b;
      logic [7:0]  y, u, v;
      logic        has_chroma;
      w = {width_reg[DIM_BITS-1:1], 1'b0};
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;

      // counters left beyond a shrunken frame wrap before use
      if (column_pos >= w) begin
         column_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;

      r = swap_reg ? int'(third) : int'(first);
      b = swap_reg ? int'(first) : int'(third);
      g = int'(green);
      y = bt601_component(r, g, b, 66, 129, 25, 16);
      u = bt601_component(r, g, b, -38, -74, 112, 128);
      v = bt601_component(r, g, b, 112, -94, -18, 128);

      col        = column_pos;
      orow       = flip_reg ? h - 1 - row_pos : row_pos;
      luma_size  = w * h;
      has_chroma = (col % 2 == 1) && ((orow % 2 == 1) || (orow == h - 1));

      awaited_writes.push_back('{PLANE_Y, ADDR_BITS'(orow * w + col), y, !has_chroma});
      if (has_chroma) begin
         chroma_offset = (orow / 2) * (w / 2) + col / 2;
         awaited_writes.push_back('{PLANE_U, ADDR_BITS'(luma_size + chroma_offset), u, 1'b0});
         awaited_writes.push_back('{PLANE_V,
                                    ADDR_BITS'(luma_size + luma_size / 4 + chroma_offset),
                                    v, 1'b1});
      end

      column_pos++;
      if (column_pos >= w) begin
         column_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   always @(posedge clock) begin
      buffer_write_type want;
      if (reset) begin
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         swap_reg   = 1'b0;
         flip_reg   = 1'b0;
         column_pos = 0;
         row_pos    = 0;
         errors     = 0;
         awaited_writes.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_WIDTH:  width_reg  = csr_wdata;
               CSR_HEIGHT: height_reg = csr_wdata;
               CSR_SWAP:   swap_reg   = csr_wdata[0];
               CSR_FLIP:   flip_reg   = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_writes.size() == 0) begin
               $error("unexpected write: plane %0d address %0d sample %0d",
                      rsp_plane, rsp_address, rsp_sample);
               errors++;
            end else begin
               want = awaited_writes.pop_front();
               if (rsp_plane !== want.plane) begin
                  $error("plane: expected %0d, got %0d", want.plane, rsp_plane);
                  errors++;
               end
               if (rsp_address !== want.address) begin
                  $error("address: expected %0d, got %0d", want.address, rsp_address);
                  errors++;
               end
               if (rsp_sample !== want.sample) begin
                  $error("sample: expected %0d, got %0d", want.sample, rsp_sample);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_pixel_writes(req_byte0, req_byte1, req_byte2);
      end
      mismatch_count <= errors;
      writes_awaited <= awaited_writes.size();
   end

endmodule

[bench/testbench.sv]
// Top of the converter bench: clock, reset, pixel and register stimulus, stall control, verdict.
`timescale 1ns / 1ps

module testbench;
   import ryp_pkg::*;

   // Cycles to hold after the last write lands or after a register write, so that the first
   // write has passed the pipe registers and the plane bases have settled.
   localparam int SETTLE_CYCLES  = 8;
   // Give up after this many cycles without a single request or write moving.
   localparam int STALL_LIMIT    = 2000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_REQUESTS = 13;
   localparam int CALM_PHASE     = 4;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [7:0]           req_byte0;
   logic [7:0]           req_byte1;
   logic [7:0]           req_byte2;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_plane;
   logic [ADDR_BITS-1:0] rsp_address;
   logic [7:0]           rsp_sample;
   logic                 rsp_last;
   logic                 csr_write;
   logic [1:0]           csr_index;
   logic [DIM_BITS-1:0]  csr_wdata;
   logic                 steady;      // suppress idling on both sides
   int                   mismatch_count;
   int                   writes_awaited;

   rgb_to_yuv420p_planar u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte0   (req_byte0),
      .req_byte1   (req_byte1),
      .req_byte2   (req_byte2),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_plane   (rsp_plane),
      .rsp_address (rsp_address),
      .rsp_sample  (rsp_sample),
      .rsp_last    (rsp_last),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   ryp_write_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte0      (req_byte0),
      .req_byte1      (req_byte1),
      .req_byte2      (req_byte2),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_plane      (rsp_plane),
      .rsp_address    (rsp_address),
      .rsp_sample     (rsp_sample),
      .rsp_last       (rsp_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .writes_awaited (writes_awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Drop rsp_ready at random about ten percent of the time, except during the calm phase.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 10);
   end

   // Bias colour bytes towards the extremes now and then, otherwise anything goes.
   function automatic logic [7:0] colour_byte();
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom);
   endfunction

   // Sizes at and beyond the clamping limits, odd and zero among them.
   function automatic logic [DIM_BITS-1:0] extreme_size();
      case ($urandom_range(0, 5))
         0:       return DIM_BITS'(0);
         1:       return DIM_BITS'(1);
         2:       return DIM_BITS'(2);
         3:       return DIM_BITS'(2047);
         4:       return DIM_BITS'(2048);
         default: return DIM_BITS'(4095);
      endcase
   endfunction

   // Offer one pixel request and hold it until taken. Valid stays high on return, so a
   // request that follows at once keeps it high unless it first inserts a random idle gap.
   task automatic send_pixel(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
      if (!steady && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte0 <= b0;
      req_byte1 <= b1;
      req_byte2 <= b2;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every predicted write has come out, then let the pipe settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (writes_awaited != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Reprogram the frame while the block is idle: all four registers back to back.
   task automatic set_frame(input logic [DIM_BITS-1:0] width, input logic [DIM_BITS-1:0] height,
                            input logic swap, input logic flip);
      drain();
      csr_write <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= width;
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= height;
      @(posedge clock);
      csr_index <= CSR_SWAP;
      csr_wdata <= DIM_BITS'(swap);
      @(posedge clock);
      csr_index <= CSR_FLIP;
      csr_wdata <= DIM_BITS'(flip);
      @(posedge clock);
      csr_write <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;

      // Drive every input to a known value before the first edge.
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_byte0 <= 8'h00;
      req_byte1 <= 8'h00;
      req_byte2 <= 8'h00;
      csr_write <= 1'b0;
      csr_index <= CSR_WIDTH;
      csr_wdata <= '0;
      steady    <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset frame (640 x 480): first row is even and not last, so luma only.
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);

      // One-row frame: the single row is the last, so every odd column carries chroma.
      // Put pure red, pure blue and pure green on odd columns to hit the chroma extremes.
      set_frame(DIM_BITS'(2), DIM_BITS'(1), 1'b0, 1'b0);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'h00);

      // Odd width and zero height clamp to 2 x 1; swapped byte order with mirrored rows.
      set_frame(DIM_BITS'(3), DIM_BITS'(0), 1'b1, 1'b1);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'hFF, 8'h00);

      // Oversized frame clamps to the maximum; mirroring puts row 0 on the top odd row,
      // which drives the addresses towards the end of the buffer.
      set_frame(DIM_BITS'(4095), DIM_BITS'(4095), 1'b0, 1'b1);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'h80, 8'h40, 8'h20);

      // Shrink the width under the running column so the counters have to wrap.
      set_frame(DIM_BITS'(1), DIM_BITS'(2047), 1'b0, 1'b1);
      send_pixel(8'h12, 8'h34, 8'h56);
      send_pixel(8'hFE, 8'h01, 8'h7F);

      // Random frames with random pixels; counters carry over from phase to phase.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0: begin
               width  = DIM_BITS'($urandom_range(0, 9));
               height = DIM_BITS'($urandom_range(0, 4));
            end
            1: begin
               width  = DIM_BITS'($urandom_range(2, 64));
               height = DIM_BITS'($urandom_range(1, 16));
            end
            2: begin
               width  = extreme_size();
               height = extreme_size();
            end
            default: begin
               width  = DIM_BITS'($urandom);
               height = DIM_BITS'($urandom);
            end
         endcase
         set_frame(width, height, 1'($urandom), 1'($urandom));
         steady <= (phase == CALM_PHASE);
         repeat (PHASE_REQUESTS) send_pixel(colour_byte(), colour_byte(), colour_byte());
      end

      steady <= 1'b0;
      drain();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog: end the run if neither a request nor a write moves for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[files.f]
design/ryp_pkg.sv
design/ryp_front.sv
design/ryp_queue.sv
design/ryp_back.sv
design/rgb_to_yuv420p_planar.sv
bench/ryp_write_checker.sv
bench/testbench.sv
